// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property on a clock with a synchronous reset that disables it
`define MSTU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mstu assertion failed");

// condition that must never be seen on a clock edge
`define MSTU_ASSERT_NEVER(lbl, clk, rst, cond) \
   `MSTU_ASSERT(lbl, clk, rst, !(cond))

`endif

// ----- sv/mstu_pkg.sv -----
// ----------------------------------------------------------------------------
// mstu_pkg
// Shared constants, codes and IEEE single arithmetic for the matrix stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mstu_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int WORD_W          = 32;
   localparam int MAT_ELEMS       = 16;

   // request codes
   localparam logic [2:0] REQ_STAGE = 3'd0;
   localparam logic [2:0] REQ_LOAD  = 3'd1;
   localparam logic [2:0] REQ_MUL   = 3'd2;
   localparam logic [2:0] REQ_PUSH  = 3'd3;
   localparam logic [2:0] REQ_POP   = 3'd4;
   localparam logic [2:0] REQ_READ  = 3'd5;
   localparam logic [2:0] REQ_COMB  = 3'd6;

   // status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_UNF = 2'd2;

   // register indexes
   localparam logic [0:0] CSR_DEPTH_NEAR = 1'b0;
   localparam logic [0:0] CSR_DEPTH_FAR  = 1'b1;

   localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
   localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QBIT = 32'h0040_0000;

   // leading zero count of a 51 bit word
   function automatic logic [5:0] clz51(input logic [50:0] v);
      logic [5:0] r;
      r = 6'd0;
      for (int i = 0; i < 51; i++) begin
         if (v[i]) r = 6'(50 - i);
      end
      return r;
   endfunction

   // n has its leading one at bit 50, e is the biased exponent of that one
   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                              input logic [50:0] n);
      logic [50:0] n2;
      logic [50:0] mask;
      logic [11:0] sh;
      logic [7:0]  ef;
      logic [23:0] m;
      logic        g;
      logic        st;
      logic        inc;
      logic [30:0] mag;
      n2   = n;
      mask = '0;
      sh   = '0;
      ef   = '0;
      if (e >= 12'sd255) begin
         return {s, 8'hFF, 23'd0};
      end
      if (e < 12'sd1) begin
         // subnormal result, shift down and keep the sticky bit
         sh = 12'(12'sd1 - e);
         if (sh > 12'd51) begin
            n2 = {50'd0, |n};
         end else begin
            mask = (51'd1 << sh) - 51'd1;
            n2   = (n >> sh) | {50'd0, |(n & mask)};
         end
         ef = 8'd0;
      end else begin
         ef = e[7:0];
      end
      m   = n2[50:27];
      g   = n2[26];
      st  = |n2[25:0];
      inc = g & (st | m[0]);
      mag = {ef, m[22:0]} + 31'(inc);
      return {s, mag};
   endfunction

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic               s;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        p;
      logic [50:0]        n;
      logic [5:0]         lz;
      logic signed [11:0] e;
      logic               az;
      logic               bz;
      s  = a[31] ^ b[31];
      az = (a[30:0] == 31'd0);
      bz = (b[30:0] == 31'd0);
      if (is_nan(a)) return a | FP_QBIT;
      if (is_nan(b)) return b | FP_QBIT;
      if ((is_inf(a) && bz) || (az && is_inf(b))) return FP_QNAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      if (az || bz) return {s, 31'd0};
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p  = ma * mb;
      n  = {p, 3'd0};
      lz = clz51(n);
      n  = n << lz;
      e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
      return round_pack(s, e, n);
   endfunction

   // a + b, or a - b when sub is set
   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b0,
                                          input logic sub);
      logic [31:0]        b;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [7:0]         ex;
      logic [7:0]         ey;
      logic [7:0]         d;
      logic [50:0]        xm;
      logic [50:0]        ym;
      logic [50:0]        mask;
      logic [50:0]        sum;
      logic [5:0]         lz;
      logic signed [11:0] e;
      b = (sub && !is_nan(b0)) ? (b0 ^ 32'h8000_0000) : b0;
      if (is_nan(a)) return a | FP_QBIT;
      if (is_nan(b)) return b | FP_QBIT;
      if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return FP_QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      if (b[30:0] > a[30:0]) begin
         x = b;
         y = a;
      end else begin
         x = a;
         y = b;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d  = ex - ey;
      xm = {1'b0, x[30:23] != 8'd0, x[22:0], 26'd0};
      ym = {1'b0, y[30:23] != 8'd0, y[22:0], 26'd0};
      mask = '0;
      if (d >= 8'd51) begin
         ym = {50'd0, 1'b1};
      end else begin
         mask = (51'd1 << d) - 51'd1;
         ym   = (ym >> d) | {50'd0, |(ym & mask)};
      end
      sum = (x[31] != y[31]) ? (xm - ym) : (xm + ym);
      if (sum == 51'd0) return 32'd0;
      lz  = clz51(sum);
      sum = sum << lz;
      e   = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
      return round_pack(x[31], e, sum);
   endfunction

endpackage

`default_nettype wire

// ----- sv/mstu_ram.sv -----
// ----------------------------------------------------------------------------
// mstu_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mstu_ram #(
   parameter int  WIDTH  = mstu_pkg::WORD_W,
   parameter int  DEPTH  = mstu_pkg::MAT_ELEMS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/matrix_stack_transform_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_stack_transform_unit
// Modelview and projection stacks of 4x4 IEEE single matrices with staging,
// load, multiply, push, pop, element read and a combined transform readout.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. Each stack sits in its own RAM of
// STACK_DEPTH*16 words, the staging matrix and a 16 word scratch matrix in
// small RAMs, all with one read and one write port. Products go through a
// single multiplier and a single adder, one term at a time through the read,
// multiply and accumulate steps. A multiply works the product into scratch,
// then copies it to the top; a combined readout forms the depth difference,
// then two products, and gives 16 results. A new transaction is taken as soon
// as the previous one has placed its last result in the output register.
`default_nettype none

module matrix_stack_transform_unit #(
   parameter int STACK_DEPTH = mstu_pkg::STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic        req_stack_sel,
   input  wire logic [3:0]  req_elem_index,
   input  wire logic [31:0] req_elem_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_value,
   output logic [3:0]       rsp_result_index,
   output logic             rsp_last_of_run,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   localparam int LW = $clog2(STACK_DEPTH);
   localparam int AW = LW + 4;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EMIT   = 3'd1;
   localparam logic [2:0] S_RDADDR = 3'd2;
   localparam logic [2:0] S_RDDATA = 3'd3;
   localparam logic [2:0] S_COPY   = 3'd4;
   localparam logic [2:0] S_DIFF   = 3'd5;
   localparam logic [2:0] S_MAC    = 3'd6;

   localparam logic [1:0] PH_READ = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ACC  = 2'd2;

   // control
   logic [2:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic          sel_ff, sel_in;
   logic [3:0]    idx_ff, idx_in;
   logic [LW-1:0] lvl_ff [2];
   logic [LW-1:0] lvl_in [2];
   logic [31:0]   near_ff, near_in;
   logic [31:0]   far_ff, far_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [3:0]    e_ff, e_in;
   logic [1:0]    k_ff, k_in;
   logic [1:0]    ph_ff, ph_in;
   logic          pass_ff, pass_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [31:0] diff_ff, diff_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] em_val_ff, em_val_in;
   logic [3:0]  em_idx_ff, em_idx_in;
   logic        em_last_ff, em_last_in;
   logic [1:0]  em_status_ff, em_status_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // memory ports
   logic          mv_wr_en, pj_wr_en, stage_wr_en, temp_wr_en;
   logic [AW-1:0] st_wr_addr, mv_rd_addr, pj_rd_addr;
   logic [31:0]   st_wr_data, stage_wr_data;
   logic [3:0]    stage_wr_addr, temp_wr_addr, stage_rd_addr, temp_rd_addr;
   logic [31:0]   mv_rd_data, pj_rd_data, stage_rd_data, temp_rd_data;

   logic [31:0]   st_rd_data;
   logic [31:0]   a_data, b_data, depth_elem;
   logic [LW-1:0] lv_sel, lv_req, lv_dst;
   logic          out_free;

   assign lv_sel   = lvl_ff[sel_ff];
   assign lv_req   = lvl_ff[req_stack_sel];
   assign lv_dst   = (op_ff == mstu_pkg::REQ_PUSH) ? (lv_sel + LW'(1)) : lv_sel;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // read addresses: a term is A[i][k] * B[k][j] with i,j from e_ff
   always_comb begin
      stage_rd_addr = (state_ff == S_COPY) ? cnt_ff[3:0] : {e_ff[3:2], k_ff};
      temp_rd_addr  = (state_ff == S_COPY) ? cnt_ff[3:0] : {k_ff, e_ff[1:0]};
      if (state_ff == S_MAC && pass_ff) begin
         mv_rd_addr = {lvl_ff[0], e_ff[3:2], k_ff};
      end else if (state_ff == S_MAC) begin
         mv_rd_addr = {lvl_ff[0], k_ff, e_ff[1:0]};
      end else if (state_ff == S_COPY) begin
         mv_rd_addr = {lvl_ff[0], cnt_ff[3:0]};
      end else begin
         mv_rd_addr = {lvl_ff[0], idx_ff};
      end
      if (state_ff == S_MAC && op_ff == mstu_pkg::REQ_COMB) begin
         pj_rd_addr = {lvl_ff[1], e_ff[3:2], k_ff};
      end else if (state_ff == S_MAC) begin
         pj_rd_addr = {lvl_ff[1], k_ff, e_ff[1:0]};
      end else if (state_ff == S_COPY) begin
         pj_rd_addr = {lvl_ff[1], cnt_ff[3:0]};
      end else begin
         pj_rd_addr = {lvl_ff[1], idx_ff};
      end
   end

   assign st_rd_data = sel_ff ? pj_rd_data : mv_rd_data;

   // depth matrix: identity with [2][2] = far - near and [3][2] = near
   always_comb begin
      case ({k_ff, e_ff[1:0]})
         4'd0, 4'd5, 4'd15: depth_elem = mstu_pkg::FP_ONE;
         4'd10:             depth_elem = diff_ff;
         4'd14:             depth_elem = near_ff;
         default:           depth_elem = 32'd0;
      endcase
   end

   always_comb begin
      if (op_ff == mstu_pkg::REQ_MUL) begin
         a_data = stage_rd_data;
         b_data = st_rd_data;
      end else if (pass_ff) begin
         a_data = mv_rd_data;
         b_data = temp_rd_data;
      end else begin
         a_data = pj_rd_data;
         b_data = depth_elem;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sel_in        = sel_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      near_in       = near_ff;
      far_in        = far_ff;
      cnt_in        = cnt_ff;
      e_in          = e_ff;
      k_in          = k_ff;
      ph_in         = ph_ff;
      pass_in       = pass_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      em_val_in     = em_val_ff;
      em_idx_in     = em_idx_ff;
      em_last_in    = em_last_ff;
      em_status_in  = em_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      stage_wr_en   = 1'b0;
      stage_wr_addr = req_elem_index;
      stage_wr_data = req_elem_value;
      temp_wr_en    = 1'b0;
      temp_wr_addr  = e_ff;
      mv_wr_en      = 1'b0;
      pj_wr_en      = 1'b0;
      st_wr_addr    = {lv_dst, 4'(cnt_ff - 5'd1)};
      case (op_ff)
         mstu_pkg::REQ_LOAD: st_wr_data = stage_rd_data;
         mstu_pkg::REQ_MUL:  st_wr_data = temp_rd_data;
         default:            st_wr_data = st_rd_data;
      endcase

      if (csr_wr_en) begin
         if (csr_index == mstu_pkg::CSR_DEPTH_NEAR) near_in = csr_wr_data;
         if (csr_index == mstu_pkg::CSR_DEPTH_FAR)  far_in  = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_type;
               sel_in       = req_stack_sel;
               idx_in       = req_elem_index;
               cnt_in       = 5'd0;
               e_in         = 4'd0;
               k_in         = 2'd0;
               ph_in        = PH_READ;
               pass_in      = 1'b0;
               em_val_in    = 32'd0;
               em_idx_in    = 4'd0;
               em_last_in   = 1'b1;
               em_status_in = mstu_pkg::ST_OK;
               case (req_type)
                  mstu_pkg::REQ_STAGE: begin
                     stage_wr_en = 1'b1;
                     em_idx_in   = req_elem_index;
                     state_in    = S_EMIT;
                  end
                  mstu_pkg::REQ_LOAD: state_in = S_COPY;
                  mstu_pkg::REQ_MUL:  state_in = S_MAC;
                  mstu_pkg::REQ_PUSH: begin
                     if (lv_req == LW'(STACK_DEPTH - 1)) begin
                        em_status_in = mstu_pkg::ST_OVF;
                        state_in     = S_EMIT;
                     end else begin
                        state_in = S_COPY;
                     end
                  end
                  mstu_pkg::REQ_POP: begin
                     if (lv_req == '0) begin
                        em_status_in = mstu_pkg::ST_UNF;
                     end else begin
                        lvl_in[req_stack_sel] = lv_req - LW'(1);
                     end
                     state_in = S_EMIT;
                  end
                  mstu_pkg::REQ_READ: state_in = S_RDADDR;
                  mstu_pkg::REQ_COMB: state_in = S_DIFF;
                  default:            state_in = S_EMIT;
               endcase
            end
         end
         S_RDADDR: state_in = S_RDDATA;
         S_RDDATA: begin
            em_val_in = st_rd_data;
            em_idx_in = idx_ff;
            state_in  = S_EMIT;
         end
         S_COPY: begin
            // read word cnt, write the word read in the previous cycle
            if (cnt_ff != 5'd0) begin
               mv_wr_en = !sel_ff;
               pj_wr_en = sel_ff;
            end
            if (cnt_ff == 5'd16) begin
               if (op_ff == mstu_pkg::REQ_PUSH) lvl_in[sel_ff] = lv_sel + LW'(1);
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIFF: begin
            diff_in  = mstu_pkg::fp_add(far_ff, near_ff, 1'b1);
            state_in = S_MAC;
         end
         S_MAC: begin
            case (ph_ff)
               PH_READ: ph_in = PH_MUL;
               PH_MUL: begin
                  prod_in = mstu_pkg::fp_mul(a_data, b_data);
                  ph_in   = PH_ACC;
               end
               default: begin
                  acc_in = (k_ff == 2'd0) ? prod_ff : mstu_pkg::fp_add(acc_ff, prod_ff, 1'b0);
                  ph_in  = PH_READ;
                  k_in   = k_ff + 2'd1;
                  if (k_ff == 2'd3) begin
                     e_in = e_ff + 4'd1;
                     if (pass_ff) begin
                        em_val_in  = acc_in;
                        em_idx_in  = e_ff;
                        em_last_in = (e_ff == 4'd15);
                        state_in   = S_EMIT;
                     end else begin
                        temp_wr_en = 1'b1;
                        if (e_ff == 4'd15) begin
                           if (op_ff == mstu_pkg::REQ_MUL) begin
                              cnt_in   = 5'd0;
                              state_in = S_COPY;
                           end else begin
                              pass_in = 1'b1;
                           end
                        end
                     end
                  end
               end
            endcase
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = em_val_ff;
               rsp_index_in  = em_idx_ff;
               rsp_last_in   = em_last_ff;
               rsp_status_in = em_status_ff;
               state_in      = em_last_ff ? S_IDLE : S_MAC;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= mstu_pkg::REQ_STAGE;
         sel_ff       <= 1'b0;
         idx_ff       <= 4'd0;
         lvl_ff[0]    <= '0;
         lvl_ff[1]    <= '0;
         near_ff      <= 32'd0;
         far_ff       <= mstu_pkg::FP_ONE;
         cnt_ff       <= 5'd0;
         e_ff         <= 4'd0;
         k_ff         <= 2'd0;
         ph_ff        <= PH_READ;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
         lvl_ff       <= lvl_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         cnt_ff       <= cnt_in;
         e_ff         <= e_in;
         k_ff         <= k_in;
         ph_ff        <= ph_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      em_val_ff     <= em_val_in;
      em_idx_ff     <= em_idx_in;
      em_last_ff    <= em_last_in;
      em_status_ff  <= em_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   mstu_ram #(.WIDTH(mstu_pkg::WORD_W), .DEPTH(STACK_DEPTH * mstu_pkg::MAT_ELEMS)) u_mv_ram (
      .clock   (clock),
      .wr_en   (mv_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (mv_rd_addr),
      .rd_data (mv_rd_data)
   );

   mstu_ram #(.WIDTH(mstu_pkg::WORD_W), .DEPTH(STACK_DEPTH * mstu_pkg::MAT_ELEMS)) u_pj_ram (
      .clock   (clock),
      .wr_en   (pj_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (pj_rd_addr),
      .rd_data (pj_rd_data)
   );

   mstu_ram #(.WIDTH(mstu_pkg::WORD_W), .DEPTH(mstu_pkg::MAT_ELEMS)) u_stage_ram (
      .clock   (clock),
      .wr_en   (stage_wr_en),
      .wr_addr (stage_wr_addr),
      .wr_data (stage_wr_data),
      .rd_addr (stage_rd_addr),
      .rd_data (stage_rd_data)
   );

   // scratch matrix for products
   mstu_ram #(.WIDTH(mstu_pkg::WORD_W), .DEPTH(mstu_pkg::MAT_ELEMS)) u_temp_ram (
      .clock   (clock),
      .wr_en   (temp_wr_en),
      .wr_addr (temp_wr_addr),
      .wr_data (acc_in),
      .rd_addr (temp_rd_addr),
      .rd_data (temp_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- sv/mstu_checker.sv -----
// ----------------------------------------------------------------------------
// mstu_checker
// Port level checks on the result channel of the matrix stack unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mstu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result_value,
   input wire logic [3:0]  rsp_result_index,
   input wire logic        rsp_last_of_run,
   input wire logic [1:0]  rsp_status
);

   `MSTU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) && $stable(rsp_result_index) && $stable(rsp_status))

   `MSTU_ASSERT_NEVER(a_status_code, clock, reset, rsp_valid && rsp_status != mstu_pkg::ST_OK && rsp_status != mstu_pkg::ST_OVF && rsp_status != mstu_pkg::ST_UNF)

   // a rejected push or pop is a single empty transaction
   `MSTU_ASSERT(a_err_single, clock, reset, rsp_valid && rsp_status != mstu_pkg::ST_OK |-> rsp_last_of_run && rsp_result_value == 32'd0 && rsp_result_index == 4'd0)

   // only the combined readout gives more than one result
   `MSTU_ASSERT(a_run_ok, clock, reset, rsp_valid && !rsp_last_of_run |-> rsp_status == mstu_pkg::ST_OK)

endmodule

bind matrix_stack_transform_unit mstu_checker u_mstu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_result_index (rsp_result_index),
   .rsp_last_of_run  (rsp_last_of_run),
   .rsp_status       (rsp_status)
);

`default_nettype wire

// ----- dv/matrix_stack_transform_unit_tb.sv -----
// ----------------------------------------------------------------------------
// matrix_stack_transform_unit_tb
// Drives stage, load, multiply, push, pop, element read and combined readout
// transactions into the matrix stack unit and checks every response against a
// single-precision model of both stacks kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_stack_transform_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DEPTH      = mstu_pkg::STACK_DEPTH_DEF;
   localparam logic [2:0]  REQ_UNUSED = 3'd7;
   localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;

   typedef logic [31:0] mat_type [16];

   typedef struct {
      logic [31:0] value;
      logic [3:0]  index;
      logic        last;
      logic [1:0]  status;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = mstu_pkg::REQ_STAGE;
   logic        req_stack_sel = 1'b0;
   logic [3:0]  req_elem_index = '0;
   logic [31:0] req_elem_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_value;
   logic [3:0]  rsp_result_index;
   logic        rsp_last_of_run;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [0:0]  csr_index = mstu_pkg::CSR_DEPTH_NEAR;
   logic [31:0] csr_wr_data = '0;

   matrix_stack_transform_unit #(.STACK_DEPTH(DEPTH)) u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model state
   logic [31:0] stack_mem [2][DEPTH][16];
   int          stack_lvl [2];
   mat_type     staging;
   logic [31:0] near_bits = 32'h0000_0000;
   logic [31:0] far_bits  = mstu_pkg::FP_ONE;
   rsp_type     pending_rsp [$];
   int          error_count = 0;
   bit          idle_on = 1'b0;
   int          stall_left = 0;

   function automatic logic nan_bits(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 0);
   endfunction

   function automatic real as_real(input logic [31:0] x);
      real r;
      if (x[30:23] == 8'd0) begin
         r = real'(int'(x[22:0])) * 2.0 ** (-149);
         return x[31] ? -r : r;
      end
      if (x[30:23] == 8'hFF) return $bitstoreal({x[31], 11'h7FF, x[22:0], 29'd0});
      return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'd0});
   endfunction

   // round a double to single, nearest even, subnormals kept
   function automatic logic [31:0] as_single(input real r);
      logic [63:0] d;
      logic [52:0] sig;
      logic [63:0] kept;
      logic [7:0]  ef;
      logic [30:0] mag;
      logic        g;
      logic        st;
      int          ue;
      int          sh;
      d = $realtobits(r);
      if (d[62:0] == 0) return {d[63], 31'd0};
      ue = int'(d[62:52]) - 1023;
      if (d[62:52] == 11'h7FF || ue > 127) return {d[63], 8'hFF, 23'd0};
      sig = {1'b1, d[51:0]};
      if (ue >= -126) begin
         sh = 29;
         ef = 8'(ue + 127);
      end else begin
         sh = 29 + (-126 - ue);
         ef = 8'd0;
      end
      if (sh > 53) begin
         kept = 0;
         g    = 1'b0;
         st   = 1'b1;
      end else begin
         kept = {11'd0, sig} >> sh;
         g    = sig[sh-1];
         st   = (sig & ((53'd1 << (sh - 1)) - 53'd1)) != 0;
      end
      mag = (ef == 0) ? 31'(kept) : {ef, kept[22:0]};
      mag = mag + 31'(g & (st | kept[0]));
      return {d[63], mag};
   endfunction

   function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      if (nan_bits(a)) return a | mstu_pkg::FP_QBIT;
      if (nan_bits(b)) return b | mstu_pkg::FP_QBIT;
      if ((a[30:0] == 31'h7F80_0000 && b[30:0] == 0) ||
          (b[30:0] == 31'h7F80_0000 && a[30:0] == 0)) return mstu_pkg::FP_QNAN;
      return as_single(as_real(a) * as_real(b));
   endfunction

   function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      if (nan_bits(a)) return a | mstu_pkg::FP_QBIT;
      if (nan_bits(b)) return b | mstu_pkg::FP_QBIT;
      if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000 && a[31] != b[31])
         return mstu_pkg::FP_QNAN;
      return as_single(as_real(a) + as_real(b));
   endfunction

   // row-major p*q, products and sums rounded one at a time in k order
   function automatic mat_type mat_product(input mat_type p, input mat_type q);
      mat_type     res;
      logic [31:0] acc;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            acc = f_mul(p[i*4], q[j]);
            for (int k = 1; k < 4; k++) acc = f_add(acc, f_mul(p[i*4+k], q[k*4+j]));
            res[i*4+j] = acc;
         end
      end
      return res;
   endfunction

   function automatic void push_rsp(input logic [31:0] v, input logic [3:0] idx,
                                    input logic last, input logic [1:0] st);
      rsp_type r;
      r.value  = v;
      r.index  = idx;
      r.last   = last;
      r.status = st;
      pending_rsp.push_back(r);
   endfunction

   function automatic void predict_transaction(input logic [2:0] op, input logic sel,
                                               input logic [3:0] idx, input logic [31:0] val);
      mat_type a;
      mat_type b;
      mat_type c;
      int      lv;
      lv = stack_lvl[sel];
      case (op)
         mstu_pkg::REQ_STAGE: begin
            staging[idx] = val;
            push_rsp('0, idx, 1'b1, mstu_pkg::ST_OK);
         end
         mstu_pkg::REQ_LOAD: begin
            for (int i = 0; i < 16; i++) stack_mem[sel][lv][i] = staging[i];
            push_rsp('0, '0, 1'b1, mstu_pkg::ST_OK);
         end
         mstu_pkg::REQ_MUL: begin
            for (int i = 0; i < 16; i++) b[i] = stack_mem[sel][lv][i];
            c = mat_product(staging, b);
            for (int i = 0; i < 16; i++) stack_mem[sel][lv][i] = c[i];
            push_rsp('0, '0, 1'b1, mstu_pkg::ST_OK);
         end
         mstu_pkg::REQ_PUSH: begin
            if (lv + 1 >= DEPTH) begin
               push_rsp('0, '0, 1'b1, mstu_pkg::ST_OVF);
            end else begin
               for (int i = 0; i < 16; i++) stack_mem[sel][lv+1][i] = stack_mem[sel][lv][i];
               stack_lvl[sel] = lv + 1;
               push_rsp('0, '0, 1'b1, mstu_pkg::ST_OK);
            end
         end
         mstu_pkg::REQ_POP: begin
            if (lv == 0) begin
               push_rsp('0, '0, 1'b1, mstu_pkg::ST_UNF);
            end else begin
               stack_lvl[sel] = lv - 1;
               push_rsp('0, '0, 1'b1, mstu_pkg::ST_OK);
            end
         end
         mstu_pkg::REQ_READ: push_rsp(stack_mem[sel][lv][idx], idx, 1'b1, mstu_pkg::ST_OK);
         mstu_pkg::REQ_COMB: begin
            for (int i = 0; i < 16; i++) begin
               a[i] = stack_mem[1][stack_lvl[1]][i];
               b[i] = (i % 5 == 0) ? mstu_pkg::FP_ONE : 32'd0;
            end
            if (nan_bits(far_bits)) b[10] = far_bits | mstu_pkg::FP_QBIT;
            else if (nan_bits(near_bits)) b[10] = near_bits | mstu_pkg::FP_QBIT;
            else b[10] = f_add(far_bits, near_bits ^ SIGN_BIT);
            b[14] = near_bits;
            c = mat_product(a, b);
            for (int i = 0; i < 16; i++) a[i] = stack_mem[0][stack_lvl[0]][i];
            c = mat_product(a, c);
            for (int i = 0; i < 16; i++) push_rsp(c[i], 4'(i), i == 15, mstu_pkg::ST_OK);
         end
         default: push_rsp('0, '0, 1'b1, mstu_pkg::ST_OK);
      endcase
   endfunction

   // sends one transaction; valid stays up into the next call unless it idles
   task automatic send_req(input logic [2:0] op, input logic sel, input logic [3:0] idx,
                           input logic [31:0] val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_stack_sel  <= sel;
      req_elem_index <= idx;
      req_elem_value <= val;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_transaction(op, sel, idx, val);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == mstu_pkg::CSR_DEPTH_NEAR) near_bits = data;
      else far_bits = data;
   endtask

   function automatic logic [31:0] rand_float;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
      if (pick < 8) return $urandom;
      case ($urandom_range(0, 6))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {1'($urandom), 8'hFF, 23'd0};
         3: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
         4: return {1'($urandom), 8'd0, 23'($urandom)};
         5: return 32'h7F7F_FFFF;
         default: return mstu_pkg::FP_ONE;
      endcase
   endfunction

   // response checker: sample mid-cycle, transaction completes on next edge
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response value=%h", rsp_result_value);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_result_value !== want.value) begin
               $error("result_value: expected %h, got %h", want.value, rsp_result_value);
               error_count++;
            end
            if (rsp_result_index !== want.index) begin
               $error("result_index: expected %0d, got %0d", want.index, rsp_result_index);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // every staging element and both stack bottoms get defined first
   task automatic test_basic_ops;
      logic [31:0] pats [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
                                mstu_pkg::FP_ONE};
      for (int i = 0; i < 16; i++)
         send_req(mstu_pkg::REQ_STAGE, 1'b0, 4'(i),
                  (i % 5 == 0) ? pats[i/5] : 32'(i) << 20);
      send_req(mstu_pkg::REQ_LOAD, 1'b0, 4'd0, '0);
      send_req(mstu_pkg::REQ_LOAD, 1'b1, 4'd15, 32'hFFFF_FFFF);
      send_req(mstu_pkg::REQ_READ, 1'b0, 4'd15, '0);
      send_req(mstu_pkg::REQ_READ, 1'b1, 4'd0, '0);
      send_req(mstu_pkg::REQ_POP, 1'b1, 4'd0, '0);
      send_req(mstu_pkg::REQ_MUL, 1'b0, 4'd0, '0);
      send_req(mstu_pkg::REQ_COMB, 1'b1, 4'd0, '0);
      send_req(REQ_UNUSED, 1'b1, 4'd15, 32'hFFFF_FFFF);
      send_req(mstu_pkg::REQ_PUSH, 1'b0, 4'd0, '0);
      send_req(mstu_pkg::REQ_POP, 1'b0, 4'd0, '0);
   endtask

   task automatic test_stack_limits;
      for (int i = 0; i < DEPTH; i++) send_req(mstu_pkg::REQ_PUSH, 1'b1, 4'd0, '0);
      send_req(mstu_pkg::REQ_READ, 1'b1, 4'd7, '0);
      for (int i = 0; i < DEPTH; i++) send_req(mstu_pkg::REQ_POP, 1'b1, 4'd0, '0);
   endtask

   task automatic test_depth_regs;
      logic [31:0] nears [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h3F00_0000};
      logic [31:0] fars  [4] = '{32'h7F7F_FFFF, mstu_pkg::FP_ONE, 32'h0000_0000,
                                 32'hFF80_0000};
      for (int i = 0; i < 4; i++) begin
         drain();
         write_csr(mstu_pkg::CSR_DEPTH_NEAR, nears[i]);
         write_csr(mstu_pkg::CSR_DEPTH_FAR, fars[i]);
         send_req(mstu_pkg::REQ_COMB, i[0], 4'd0, '0);
      end
      drain();
      write_csr(mstu_pkg::CSR_DEPTH_NEAR, 32'h0000_0000);
      write_csr(mstu_pkg::CSR_DEPTH_FAR, mstu_pkg::FP_ONE);
   endtask

   task automatic test_random_mix(input int count);
      int w;
      logic [2:0] op;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         if (n == count - 30) idle_on = 1'b0;
         else if (n % 40 == 0) idle_on = (n % 80 == 0);
         w = $urandom_range(0, 99);
         if (w < 33) op = mstu_pkg::REQ_STAGE;
         else if (w < 41) op = mstu_pkg::REQ_LOAD;
         else if (w < 51) op = mstu_pkg::REQ_MUL;
         else if (w < 62) op = mstu_pkg::REQ_PUSH;
         else if (w < 73) op = mstu_pkg::REQ_POP;
         else if (w < 88) op = mstu_pkg::REQ_READ;
         else if (w < 95) op = mstu_pkg::REQ_COMB;
         else op = REQ_UNUSED;
         send_req(op, 1'($urandom), 4'($urandom), rand_float());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      stack_lvl[0] = 0;
      stack_lvl[1] = 0;
      idle_on = 1'b1;
      test_basic_ops();
      test_stack_limits();
      test_depth_regs();
      idle_on = 1'b1;
      test_random_mix(125);
      drain();
      if (error_count == 0) begin
         $display("matrix_stack_transform_unit_tb: done, clean");
      end else begin
         $display("matrix_stack_transform_unit_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("matrix_stack_transform_unit_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
